/* rtl/iop_pkg.sv */
`timescale 1ns / 1ps

package iop_pkg;

	// Access kind
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Decoded port numbers
	localparam logic [7:0] PORT_SW0        = 8'd0;
	localparam logic [7:0] PORT_SW1        = 8'd1;
	localparam logic [7:0] PORT_SW2_OFFSET = 8'd2;
	localparam logic [7:0] PORT_SHIFT_SND1 = 8'd3;
	localparam logic [7:0] PORT_SHIFT_DATA = 8'd4;
	localparam logic [7:0] PORT_SND2       = 8'd5;
	localparam logic [7:0] PORT_WATCHDOG   = 8'd6;

	// Bits forced high on switch reads, and the idle bus value
	localparam logic [7:0] SW0_FORCE_MASK = 8'h0E;
	localparam logic [7:0] SW1_FORCE_MASK = 8'h08;
	localparam logic [7:0] OFFSET_MASK    = 8'h07;
	localparam logic [7:0] BUS_IDLE       = 8'hFF;

	// Write strobes into the shift register unit
	typedef struct packed {
		logic       load_word;
		logic       load_offset;
		logic [7:0] data;
	} iop_shift_ctl_t;

endpackage

/* rtl/iop_if.sv */
`timescale 1ns / 1ps

// Request channel: one port access per transaction
interface iop_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] port;
	logic [7:0] write_data;
	logic [7:0] switches0;
	logic [7:0] switches1;
	logic [7:0] switches2;

	modport source (
		output valid, req_type, port, write_data, switches0, switches1, switches2,
		input  ready
	);
	modport sink (
		input  valid, req_type, port, write_data, switches0, switches1, switches2,
		output ready
	);
endinterface

// Response channel: one result per transaction
interface iop_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       unhandled;

	modport source (
		output valid, read_data, unhandled,
		input  ready
	);
	modport sink (
		input  valid, read_data, unhandled,
		output ready
	);
endinterface

/* rtl/io_ports_with_barrel_shifter_top.sv */
`timescale 1ns / 1ps

// I/O port block with a 16-bit shift register window. Each request transaction is
// one 8-bit port access (read or write) and yields exactly one response transaction
// carrying read_data and an unhandled flag. Reads of ports 0..2 return the switch
// bytes (with fixed bits forced high on ports 0 and 1), a read of port 3 returns
// the shift register window; writes to port 2 set the window offset and writes to
// port 4 shift a byte in. The block takes one access per clock while responses are
// taken: an access is registered on acceptance, decoded and applied to the shift
// state as it advances into the output register, and its result lands in the
// output register, which holds the response. The output register only stalls the
// input register when the response is not taken.

module io_ports_with_barrel_shifter_top
	import iop_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	iop_req_if.sink   req,
	iop_rsp_if.source rsp
);

	logic       valid_s1;
	logic       req_type_s1;
	logic [7:0] port_s1;
	logic [7:0] write_data_s1;
	logic [7:0] switches0_s1;
	logic [7:0] switches1_s1;
	logic [7:0] switches2_s1;

	logic       valid_s2;
	logic [7:0] read_data_s2;
	logic       unhandled_s2;

	logic           adv_s1;
	logic           take_req;
	iop_shift_ctl_t shift_ctl;
	logic [7:0]     window;
	logic [7:0]     rd_next;
	logic           bad_next;

	// Advance stage 1 into the output register when it is free or drains
	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign take_req  = req.valid && req.ready;

	// Capture the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			req_type_s1   <= req.req_type;
			port_s1       <= req.port;
			write_data_s1 <= req.write_data;
			switches0_s1  <= req.switches0;
			switches1_s1  <= req.switches1;
			switches2_s1  <= req.switches2;
		end
	end

	// Decode the access
	always_comb begin
		rd_next   = '0;
		bad_next  = 1'b0;
		shift_ctl = '{load_word: 1'b0, load_offset: 1'b0, data: write_data_s1};
		if (req_type_s1 == REQ_READ) begin
			case (port_s1)
				PORT_SW0:        rd_next = switches0_s1 | SW0_FORCE_MASK;
				PORT_SW1:        rd_next = switches1_s1 | SW1_FORCE_MASK;
				PORT_SW2_OFFSET: rd_next = switches2_s1;
				PORT_SHIFT_SND1: rd_next = window;
				default: begin
					rd_next  = BUS_IDLE;
					bad_next = 1'b1;
				end
			endcase
		end else begin
			case (port_s1)
				PORT_SW2_OFFSET: shift_ctl.load_offset = adv_s1;
				PORT_SHIFT_DATA: shift_ctl.load_word   = adv_s1;
				PORT_SHIFT_SND1, PORT_SND2, PORT_WATCHDOG: bad_next = 1'b0;
				default:         bad_next = 1'b1;
			endcase
		end
	end

	iop_shifter u_shifter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (shift_ctl),
		.window (window)
	);

	// Hold the result until the response transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_data_s2 <= rd_next;
			unhandled_s2 <= bad_next;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.read_data = read_data_s2;
	assign rsp.unhandled = unhandled_s2;

endmodule

/* rtl/iop_shifter.sv */
`timescale 1ns / 1ps

module iop_shifter
	import iop_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  iop_shift_ctl_t ctl,
	output logic [7:0]     window
);

	logic [15:0] word_q;
	logic [2:0]  offset_q;
	logic [3:0]  amount;
	logic [15:0] shifted;

	// Update shift word and window offset on writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q   <= '0;
			offset_q <= '0;
		end else begin
			if (ctl.load_word) begin
				word_q <= {ctl.data, word_q[15:8]};
			end
			if (ctl.load_offset) begin
				offset_q <= ctl.data[2:0] & OFFSET_MASK[2:0];
			end
		end
	end

	// Pick the 8-bit window; offset zero gives the high byte
	always_comb begin
		amount  = 4'd8 - {1'b0, offset_q};
		shifted = word_q >> amount;
		window  = shifted[7:0];
	end

endmodule
